// File: sv/cartesian_to_polar_degrees_defines.svh
// Assertion macros for the cartesian-to-polar block.
// Defining ASSERT_OFF turns every check into an empty line.
`ifndef CARTESIAN_TO_POLAR_DEGREES_DEFINES_SVH
`define CARTESIAN_TO_POLAR_DEGREES_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define CTP_ASSERT_IMP(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("cartesian_to_polar_degrees: implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CTP_ASSERT_NXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("cartesian_to_polar_degrees: next-cycle check failed");

`else

`define CTP_ASSERT_IMP(label, clock, reset, ante, cons)
`define CTP_ASSERT_NXT(label, clock, reset, ante, cons)

`endif

`endif

// File: sv/ctp_pkg.sv
package ctp_pkg;

  // Default geometry of the coordinate and fraction fields.
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // Result field widths.
  localparam int DIST_W  = 25;
  localparam int ANGLE_W = 17;

  // The bearing is worked out in units of 1/65536 degree.
  localparam int ANG_UNIT_BITS   = 16;
  localparam int CORDIC_STEPS    = 22;
  localparam int CORDIC_PRESHIFT = 24;
  localparam int ANG_Z_W         = 24;
  localparam int ANG_T_W         = 25;

  localparam logic signed [ANG_Z_W-1:0] Z_DEG_90  = 24'sd5898240;
  localparam logic        [ANG_T_W-1:0] T_DEG_90  = 25'd5898240;
  localparam logic        [ANG_T_W-1:0] T_DEG_180 = 25'd11796480;
  localparam logic        [ANG_T_W-1:0] T_DEG_360 = 25'd23592960;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 1'b1;

  // How the first-quadrant bearing maps onto the full circle.
  typedef logic [1:0] quad_t;
  localparam quad_t QUAD_I   = 2'd0;  // base
  localparam quad_t QUAD_II  = 2'd1;  // 180 - base
  localparam quad_t QUAD_III = 2'd2;  // 180 + base
  localparam quad_t QUAD_IV  = 2'd3;  // 360 - base

  // Classification of one offset, carried alongside the bearing pipeline.
  typedef struct packed {
    logic  origin_hit;
    logic  ax_zero;
    logic  ay_zero;
    quad_t quad;
  } ctp_flags_t;

  // atan(2^-i) in degrees, scaled by 65536 and rounded.
  function automatic logic signed [ANG_Z_W-1:0] cordic_atan(input int unsigned step);
    logic signed [ANG_Z_W-1:0] v;
    unique case (step)
      0:       v = 24'sd2949120;
      1:       v = 24'sd1740966;
      2:       v = 24'sd919879;
      3:       v = 24'sd466945;
      4:       v = 24'sd234379;
      5:       v = 24'sd117304;
      6:       v = 24'sd58666;
      7:       v = 24'sd29335;
      8:       v = 24'sd14668;
      9:       v = 24'sd7334;
      10:      v = 24'sd3667;
      11:      v = 24'sd1833;
      12:      v = 24'sd917;
      13:      v = 24'sd458;
      14:      v = 24'sd229;
      15:      v = 24'sd115;
      16:      v = 24'sd57;
      17:      v = 24'sd29;
      18:      v = 24'sd14;
      19:      v = 24'sd7;
      20:      v = 24'sd4;
      21:      v = 24'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/cartesian_to_polar_degrees.sv
// Converts a stream of points into distance and bearing from a programmable
// origin. Both results carry FRAC_BITS fraction bits; the bearing runs from 0
// up to but not including 360 degrees, counter-clockwise from the +x axis, and
// a point on the origin gives zero for both. One point is taken every cycle
// unless point_stall is raised. The square root resolves one root bit per
// pipeline stage over (2*COORD_BITS + 2*FRAC_BITS + 2) / 2 root bits and is
// the longer of the two datapaths at the default widths. A stall on the
// result side holds only full stages, so empty stages keep filling until
// the whole pipeline is occupied. Origin writes are accepted in any cycle
// and should be made while no point is in flight.
`include "cartesian_to_polar_degrees_defines.svh"

module cartesian_to_polar_degrees import ctp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         point_valid,
  output logic                         point_stall,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic        [DIST_W-1:0]     distance,
  output logic        [ANGLE_W-1:0]    angle_deg,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [COORD_BITS-1:0] cfg_data
);

  localparam int N_W      = 2 * COORD_BITS + 1 + 2 * FRAC_BITS;
  localparam int RB       = (N_W + 1) / 2;
  localparam int DIST_LAT = RB + 3;
  localparam int ANG_LAT  = CORDIC_STEPS + 2;
  localparam int LAT      = (DIST_LAT > ANG_LAT) ? DIST_LAT : ANG_LAT;

  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic        [LAT:0]          en_all;
  logic        [COORD_BITS-1:0] ax;
  logic        [COORD_BITS-1:0] ay;
  ctp_flags_t                   flags;

  // Origin registers; a write word is taken in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x <= $signed(cfg_data);
        REG_ORIGIN_Y: origin_y <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Pipeline control for the front stage and both datapaths.
  ctp_ctrl #(
    .DEPTH (LAT + 1)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point_valid),
    .in_stall  (point_stall),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .en        (en_all)
  );

  ctp_front #(
    .CB (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .en       (en_all[0]),
    .point_x  (point_x),
    .point_y  (point_y),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .ax       (ax),
    .ay       (ay),
    .flags    (flags)
  );

  ctp_dist #(
    .CB  (COORD_BITS),
    .FB  (FRAC_BITS),
    .LAT (LAT)
  ) u_dist (
    .clk      (clk),
    .en       (en_all[LAT:1]),
    .ax       (ax),
    .ay       (ay),
    .distance (distance)
  );

  ctp_angle #(
    .CB  (COORD_BITS),
    .FB  (FRAC_BITS),
    .LAT (LAT)
  ) u_angle (
    .clk       (clk),
    .en        (en_all[LAT:1]),
    .ax        (ax),
    .ay        (ay),
    .flags     (flags),
    .angle_deg (angle_deg)
  );

  // Back-pressure on points only ever comes from a held result word.
  `CTP_ASSERT_IMP(a_stall_source, clk, rst, point_stall, result_valid && result_stall)
  // A zero distance only comes from a point on the origin, whose bearing is zero.
  `CTP_ASSERT_IMP(a_origin_aligned, clk, rst, result_valid && distance == '0, angle_deg == '0)

endmodule

// File: sv/ctp_ctrl.sv
// Valid bits and per-stage load enables of the pipeline. A stage loads when
// the output is free or any stage from it to the end is empty, so bubbles
// close up under a stall and no word is lost or repeated.
module ctp_ctrl import ctp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [DEPTH-1:0] en
);

  logic [DEPTH-1:0] v;

  // Load enable of each stage.
  for (genvar k = 0; k < DEPTH; k++) begin : g_en
    assign en[k] = !out_stall || !(&v[DEPTH-1:k]);
  end

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < DEPTH; k++) begin
        if (en[k]) begin
          v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[DEPTH-1];

endmodule

// File: sv/ctp_front.sv
// Offset from the origin, its magnitudes and its quadrant, registered.
module ctp_front import ctp_pkg::*; #(
  parameter int CB = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CB-1:0] point_x,
  input  logic signed [CB-1:0] point_y,
  input  logic signed [CB-1:0] origin_x,
  input  logic signed [CB-1:0] origin_y,
  output logic        [CB-1:0] ax,
  output logic        [CB-1:0] ay,
  output ctp_flags_t           flags
);

  logic signed [CB:0] dx;
  logic signed [CB:0] dy;
  quad_t              quad;

  assign dx = $signed({point_x[CB-1], point_x}) - $signed({origin_x[CB-1], origin_x});
  assign dy = $signed({point_y[CB-1], point_y}) - $signed({origin_y[CB-1], origin_y});

  // Pick the mapping from the first-quadrant angle to the full circle.
  always_comb begin
    priority if (dx > 0 && !dy[CB]) begin
      quad = QUAD_I;
    end else if (dx[CB] && !dy[CB]) begin
      quad = QUAD_II;
    end else if (dx[CB]) begin
      quad = QUAD_III;
    end else if (dy[CB]) begin
      quad = QUAD_IV;
    end else begin
      quad = QUAD_I;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax               <= dx[CB] ? CB'(-dx) : CB'(dx);
      ay               <= dy[CB] ? CB'(-dy) : CB'(dy);
      flags.origin_hit <= (dx == '0) && (dy == '0);
      flags.ax_zero    <= (dx == '0);
      flags.ay_zero    <= (dy == '0);
      flags.quad       <= quad;
    end
  end

endmodule

// File: sv/ctp_dist.sv
// Distance pipeline: squares, scaled sum, then a digit-by-digit square root
// that settles one root bit per stage, and a final round to nearest.
module ctp_dist import ctp_pkg::*; #(
  parameter int CB  = COORD_BITS_DEF,
  parameter int FB  = FRAC_BITS_DEF,
  parameter int LAT = 28
) (
  input  logic                clk,
  input  logic [LAT-1:0]      en,
  input  logic [CB-1:0]       ax,
  input  logic [CB-1:0]       ay,
  output logic [DIST_W-1:0]   distance
);

  localparam int SQ_W  = 2 * CB;
  localparam int N_W   = 2 * CB + 1 + 2 * FB;
  localparam int RB    = (N_W + 1) / 2;
  localparam int N2    = 2 * RB;
  localparam int REM_W = RB + 3;
  localparam int PAD   = LAT - (RB + 3);

  logic [SQ_W-1:0]   sqa;
  logic [SQ_W-1:0]   sqb;
  logic [N2-1:0]     radicand;
  logic [N2-1:0]     rad_r [RB];
  logic [REM_W-1:0]  rem_r [RB];
  logic [RB-1:0]     q_r   [RB];
  logic [DIST_W-1:0] dist_core;
  logic [RB:0]       q_round;

  // Squares of the two magnitudes.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sqa <= SQ_W'(ax) * SQ_W'(ax);
      sqb <= SQ_W'(ay) * SQ_W'(ay);
    end
  end

  // Sum of squares, scaled for the fraction bits of the root.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      radicand <= (N2'(sqa) + N2'(sqb)) << (2 * FB);
    end
  end

  // One root bit per stage, most significant first.
  for (genvar k = 0; k < RB; k++) begin : g_root
    logic [N2-1:0]    rad_in;
    logic [REM_W-1:0] rem_in;
    logic [RB-1:0]    q_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rad_in = radicand;
      assign rem_in = '0;
      assign q_in   = '0;
    end else begin : g_next
      assign rad_in = rad_r[k-1];
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign rem_sh = {rem_in[RB:0], rad_in[N2-1 -: 2]};
    assign trial  = REM_W'({q_in, 2'b01});

    always_ff @(posedge clk) begin
      if (en[2+k]) begin
        rad_r[k] <= rad_in << 2;
        if (rem_sh >= trial) begin
          rem_r[k] <= rem_sh - trial;
          q_r[k]   <= {q_in[RB-2:0], 1'b1};
        end else begin
          rem_r[k] <= rem_sh;
          q_r[k]   <= {q_in[RB-2:0], 1'b0};
        end
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the root.
  assign q_round = {1'b0, q_r[RB-1]}
                 + (RB+1)'(rem_r[RB-1] > REM_W'(q_r[RB-1]));

  always_ff @(posedge clk) begin
    if (en[RB+2]) begin
      dist_core <= DIST_W'(q_round);
    end
  end

  // Delay to line up with the bearing pipeline.
  if (PAD > 0) begin : g_pad
    logic [DIST_W-1:0] pd [PAD];
    for (genvar j = 0; j < PAD; j++) begin : g_tap
      if (j == 0) begin : g_head
        always_ff @(posedge clk) begin
          if (en[RB+3+j]) begin
            pd[j] <= dist_core;
          end
        end
      end else begin : g_tail
        always_ff @(posedge clk) begin
          if (en[RB+3+j]) begin
            pd[j] <= pd[j-1];
          end
        end
      end
    end
    assign distance = pd[PAD-1];
  end else begin : g_nopad
    assign distance = dist_core;
  end

endmodule

// File: sv/ctp_angle.sv
// Bearing pipeline: one vectoring rotation per stage over the first quadrant,
// then clamping and quadrant mapping, then rounding and wrap at 360 degrees.
module ctp_angle import ctp_pkg::*; #(
  parameter int CB  = COORD_BITS_DEF,
  parameter int FB  = FRAC_BITS_DEF,
  parameter int LAT = 28
) (
  input  logic               clk,
  input  logic [LAT-1:0]     en,
  input  logic [CB-1:0]      ax,
  input  logic [CB-1:0]      ay,
  input  ctp_flags_t         flags,
  output logic [ANGLE_W-1:0] angle_deg
);

  localparam int XW  = CB + 27;
  localparam int AW  = ANG_T_W + 2;
  localparam int G   = ANG_UNIT_BITS - FB;
  localparam int PAD = LAT - (CORDIC_STEPS + 2);

  logic signed [XW-1:0]      x0;
  logic signed [XW-1:0]      y0;
  logic signed [XW-1:0]      xr [CORDIC_STEPS];
  logic signed [XW-1:0]      yr [CORDIC_STEPS];
  logic signed [ANG_Z_W-1:0] zr [CORDIC_STEPS];
  ctp_flags_t                fr [CORDIC_STEPS];
  logic signed [ANG_Z_W-1:0] z_fin;
  ctp_flags_t                f_fin;
  logic [ANG_T_W-1:0]        base;
  logic [ANG_T_W-1:0]        t_next;
  logic [ANG_T_W-1:0]        t_reg;
  logic [AW-1:0]             rnd;
  logic [AW-1:0]             ang;
  logic [AW-1:0]             full;
  logic [ANGLE_W-1:0]        ang_core;

  assign x0 = $signed({{(XW-CB){1'b0}}, ax}) <<< CORDIC_PRESHIFT;
  assign y0 = $signed({{(XW-CB){1'b0}}, ay}) <<< CORDIC_PRESHIFT;

  // Rotation stages: drive y towards zero and accumulate the angle.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [XW-1:0]      x_in;
    logic signed [XW-1:0]      y_in;
    logic signed [ANG_Z_W-1:0] z_in;
    ctp_flags_t                f_in;
    logic signed [XW-1:0]      xsh;
    logic signed [XW-1:0]      ysh;

    if (i == 0) begin : g_first
      assign x_in = x0;
      assign y_in = y0;
      assign z_in = '0;
      assign f_in = flags;
    end else begin : g_next
      assign x_in = xr[i-1];
      assign y_in = yr[i-1];
      assign z_in = zr[i-1];
      assign f_in = fr[i-1];
    end

    assign xsh = x_in >>> i;
    assign ysh = y_in >>> i;

    always_ff @(posedge clk) begin
      if (en[i]) begin
        fr[i] <= f_in;
        if (!y_in[XW-1]) begin
          xr[i] <= x_in + ysh;
          yr[i] <= y_in - xsh;
          zr[i] <= z_in + cordic_atan(i);
        end else begin
          xr[i] <= x_in - ysh;
          yr[i] <= y_in + xsh;
          zr[i] <= z_in - cordic_atan(i);
        end
      end
    end
  end

  assign z_fin = zr[CORDIC_STEPS-1];
  assign f_fin = fr[CORDIC_STEPS-1];

  // First-quadrant angle: axis cases are exact, otherwise the clamped result.
  always_comb begin
    priority if (f_fin.ay_zero) begin
      base = '0;
    end else if (f_fin.ax_zero) begin
      base = T_DEG_90;
    end else if (z_fin[ANG_Z_W-1]) begin
      base = '0;
    end else if (z_fin > Z_DEG_90) begin
      base = T_DEG_90;
    end else begin
      base = ANG_T_W'($unsigned(z_fin));
    end
  end

  // Map onto the full circle; a point on the origin gives zero.
  always_comb begin
    unique case (f_fin.quad)
      QUAD_I:   t_next = base;
      QUAD_II:  t_next = T_DEG_180 - base;
      QUAD_III: t_next = T_DEG_180 + base;
      QUAD_IV:  t_next = T_DEG_360 - base;
      default:  t_next = base;
    endcase
    if (f_fin.origin_hit) begin
      t_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[CORDIC_STEPS]) begin
      t_reg <= t_next;
    end
  end

  // Round to the output fraction, half up, and wrap a full turn to zero.
  assign rnd  = (AW'(t_reg) << 1) + (AW'(1) << G);
  assign ang  = rnd >> (G + 1);
  assign full = AW'(360) << FB;

  always_ff @(posedge clk) begin
    if (en[CORDIC_STEPS+1]) begin
      ang_core <= (ang >= full) ? ANGLE_W'(ang - full) : ANGLE_W'(ang);
    end
  end

  // Delay to line up with the distance pipeline.
  if (PAD > 0) begin : g_pad
    logic [ANGLE_W-1:0] pd [PAD];
    for (genvar j = 0; j < PAD; j++) begin : g_tap
      if (j == 0) begin : g_head
        always_ff @(posedge clk) begin
          if (en[CORDIC_STEPS+2+j]) begin
            pd[j] <= ang_core;
          end
        end
      end else begin : g_tail
        always_ff @(posedge clk) begin
          if (en[CORDIC_STEPS+2+j]) begin
            pd[j] <= pd[j-1];
          end
        end
      end
    end
    assign angle_deg = pd[PAD-1];
  end else begin : g_nopad
    assign angle_deg = ang_core;
  end

endmodule
